/* src/lbc_pkg.sv */
// Shared types, constants and helpers for the line black level clamp.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lbc_pkg;

  // Field and counter widths fixed by the stream format.
  localparam int PIX_W   = 8;
  localparam int WIN_W   = 11;
  localparam int LINE_W  = 11;
  localparam int SUM_W   = 13;
  localparam int CMP_W   = 12;
  localparam int IDX_W   = 4;
  localparam int CFG_W   = 11;

  // Default sizes of the raw line and of the output window.
  localparam int DEF_RAW_PITCH    = 1558;
  localparam int DEF_MAX_WIDTH    = 1280;
  localparam int DEF_MAX_LINES    = 1024;
  localparam int DEF_ACTIVE_START = 20;

  // Optical black columns: two half-open ranges, 23 bytes in total.
  localparam logic [CMP_W-1:0] DARK_A_LO = CMP_W'(3);
  localparam logic [CMP_W-1:0] DARK_A_HI = CMP_W'(18);
  localparam logic [CMP_W-1:0] DARK_B_LO = CMP_W'(1301);
  localparam logic [CMP_W-1:0] DARK_B_HI = CMP_W'(1309);

  localparam logic [LINE_W-1:0] LINE_SAT = '1;

  // Division by 23 as multiply by ceil(2^17/23) and shift; exact below 26214.
  localparam int DIV23_MUL   = 5699;
  localparam int DIV23_SHIFT = 17;

  // Output queue between the front and the back part.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  typedef enum logic [IDX_W-1:0] {
    CFG_DENOISE      = IDX_W'(0),
    CFG_WINDOW_X     = IDX_W'(1),
    CFG_WINDOW_WIDTH = IDX_W'(2),
    CFG_ACTIVE_LINES = IDX_W'(3)
  } cfg_idx_t;

  typedef struct packed {
    logic             denoise_enable;
    logic [WIN_W-1:0] window_x;
    logic [WIN_W-1:0] window_width;
    logic [WIN_W-1:0] active_lines;
  } cfg_t;

  // One queued result before the offset is applied.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] offset;
    logic             denoise;
    logic             line_end;
    logic             frame_end;
  } q_entry_t;

  function automatic logic [PIX_W-1:0] div23_sat(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] p;
    logic [2*SUM_W-DIV23_SHIFT-1:0] q;
    p = s * SUM_W'(DIV23_MUL);
    q = p[2*SUM_W-1:DIV23_SHIFT];
    div23_sat = (q > (2*SUM_W-DIV23_SHIFT)'(255)) ? '1 : q[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/lbc_front.sv */
// Front part: column and line counting, dark sum and offset, line store.
// Issues one store read per transfer and hands results to the queue.
// Depends on lbc_pkg.
`default_nettype none

module lbc_front
  import lbc_pkg::*;
#(
  parameter int RAW_PITCH    = DEF_RAW_PITCH,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_LINES    = DEF_MAX_LINES,
  parameter int ACTIVE_START = DEF_ACTIVE_START
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [PIX_W-1:0] raw_pixel,
  input  wire logic             frame_start,
  input  wire cfg_t             cfg,
  output logic                  push,
  output q_entry_t              push_data
);

  localparam int CW = $clog2(RAW_PITCH);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [CW-1:0]     column_count;
  logic [LINE_W-1:0] line_count;
  logic [SUM_W-1:0]  dark_sum;
  logic [PIX_W-1:0]  held_offset;
  logic              held_valid;

  logic [PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  rd_data;

  logic              s1_valid;
  logic [PIX_W-1:0]  s1_offset;
  logic              s1_denoise;
  logic              s1_line_end;
  logic              s1_frame_end;

  logic [WIN_W-1:0]  room;
  logic [WIN_W-1:0]  eff_w;
  logic [LINE_W-1:0] eff_lines;
  logic [CW-1:0]     col;
  logic [CMP_W-1:0]  col_ext;
  logic [CMP_W-1:0]  w_ext;
  logic [LINE_W-1:0] line_cur;
  logic              hv;
  logic              emit;
  logic              last_px;
  logic              col_last;
  logic              dark_in;
  logic [SUM_W-1:0]  sum_next;
  logic [CMP_W-1:0]  wbase;
  logic [CMP_W-1:0]  woff;
  logic              wr_en;

  always_comb begin
    room = WIN_W'(MAX_WIDTH) - cfg.window_x;
    if (cfg.window_x >= WIN_W'(MAX_WIDTH)) begin
      eff_w = '0;
    end else if (cfg.window_width > room) begin
      eff_w = room;
    end else begin
      eff_w = cfg.window_width;
    end
    eff_lines = (cfg.active_lines > LINE_W'(MAX_LINES)) ? LINE_W'(MAX_LINES)
                                                        : cfg.active_lines;

    // A frame start byte is column 0 of line 0 and drops any held line.
    col      = frame_start ? '0 : column_count;
    line_cur = frame_start ? '0 : line_count;
    hv       = frame_start ? 1'b0 : held_valid;
    col_ext  = CMP_W'(col);
    w_ext    = CMP_W'(eff_w);

    emit     = hv && (col_ext < w_ext);
    last_px  = (col_ext + CMP_W'(1)) == w_ext;
    col_last = col_ext >= CMP_W'(RAW_PITCH - 1);

    dark_in  = ((col_ext >= DARK_A_LO) && (col_ext < DARK_A_HI)) ||
               ((col_ext >= DARK_B_LO) && (col_ext < DARK_B_HI));
    sum_next = ((col == '0) ? '0 : dark_sum) +
               (dark_in ? SUM_W'(raw_pixel) : '0);

    wbase = CMP_W'(ACTIVE_START) + CMP_W'(cfg.window_x);
    woff  = col_ext - wbase;
    wr_en = accept && (col_ext >= wbase) && (woff < w_ext);
  end

  // Within one line every entry is read at its own column before the
  // capture of the same line reaches it, so old data is always returned.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[woff[AW-1:0]] <= raw_pixel;
    end
    if (accept) begin
      rd_data <= line_mem[col[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_count   <= '0;
      dark_sum     <= '0;
      held_offset  <= '0;
      held_valid   <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept && emit;
      if (accept) begin
        dark_sum <= sum_next;
        if (col_last) begin
          held_offset  <= div23_sat(sum_next);
          held_valid   <= line_cur < eff_lines;
          line_count   <= (line_cur != LINE_SAT) ? line_cur + LINE_W'(1) : line_cur;
          column_count <= '0;
        end else begin
          held_valid   <= hv;
          line_count   <= line_cur;
          column_count <= col + CW'(1);
        end
      end
    end
  end

  // The offset and mode travel with the item so a stalled result keeps them.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_offset    <= held_offset;
      s1_denoise   <= cfg.denoise_enable;
      s1_line_end  <= last_px;
      s1_frame_end <= last_px && (line_cur == eff_lines);
    end
  end

  assign push                = s1_valid;
  assign push_data.pixel     = rd_data;
  assign push_data.offset    = s1_offset;
  assign push_data.denoise   = s1_denoise;
  assign push_data.line_end  = s1_line_end;
  assign push_data.frame_end = s1_frame_end;

endmodule

`default_nettype wire

/* src/lbc_queue.sv */
// Short result queue between the front and the back part.
// Depends on lbc_pkg for the entry type and depth.
`default_nettype none

module lbc_queue
  import lbc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire q_entry_t  push_data,
  input  wire logic      pop,
  output q_entry_t       pop_data,
  output logic           not_empty,
  output logic [QLVL_W-1:0] level
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  assign not_empty = level != '0;
  assign pop_data  = slots[rd_ptr];

endmodule

`default_nettype wire

/* src/lbc_back.sv */
// Back part: applies the black offset with clamping and drives the output
// register of the master stream. Depends on lbc_pkg.
`default_nettype none

module lbc_back
  import lbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_not_empty,
  input  wire q_entry_t         q_data,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser
);

  logic [PIX_W-1:0] corrected;

  always_comb begin
    if (q_data.denoise) begin
      corrected = (q_data.pixel >= q_data.offset) ? q_data.pixel - q_data.offset : '0;
    end else begin
      corrected = q_data.pixel;
    end
  end

  assign pop = q_not_empty && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= corrected;
      m_axis_tlast <= q_data.line_end;
      m_axis_tuser <= q_data.frame_end;
    end
  end

endmodule

`default_nettype wire

/* src/line_black_level_clamp_unit.sv */
// Line black level clamp: raw sensor lines in, window pixels of the previous
// line out, offset-corrected if denoise is set. Holds the config registers.
// Depends on lbc_pkg, lbc_front, lbc_queue and lbc_back.
//
// Usage:
//   Slave stream: one raw byte per transfer; tuser marks the first byte of a
//   frame, which restarts column and line counting and drops a held line.
//   Master stream: pixels of the held window line, emitted while columns
//   0..width-1 of the following raw line arrive; tlast ends an output line,
//   tuser marks the last pixel of the last active line.
//   Config port: index 0 denoise, 1 window x, 2 window width, 3 active
//   lines; other indexes are ignored. Always ready; write while idle.
// Timing:
//   One byte per cycle sustained while the queue has room. A result passes
//   through the read stage, the queue and the output register: the line store is
//   read at the transfer edge, the queue takes the result from the read stage,
//   and the offset subtract lands in the output register when it is popped.
//   After reset nothing is emitted until one full raw line is captured.
//   When the receiver stalls, results collect in a four-entry queue and
//   s_axis_tready drops once the queue and the read stage hold four items.
`default_nettype none

module line_black_level_clamp_unit
  import lbc_pkg::*;
#(
  parameter int RAW_PITCH    = DEF_RAW_PITCH,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_LINES    = DEF_MAX_LINES,
  parameter int ACTIVE_START = DEF_ACTIVE_START
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [PIX_W-1:0] s_axis_tdata,   // [7:0] raw_pixel
  input  wire logic             s_axis_tuser,   // [0] frame_start
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                  m_axis_tlast,   // line_end
  output logic                  m_axis_tuser,   // [0] frame_end
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              accept;
  logic              push;
  q_entry_t          push_data;
  logic              pop;
  q_entry_t          pop_data;
  logic              q_not_empty;
  logic [QLVL_W-1:0] q_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.denoise_enable <= 1'b0;
      cfg.window_x       <= '0;
      cfg.window_width   <= WIN_W'(DEF_MAX_WIDTH);
      cfg.active_lines   <= WIN_W'(DEF_MAX_LINES);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DENOISE:      cfg.denoise_enable <= cfg_data[0];
        CFG_WINDOW_X:     cfg.window_x       <= cfg_data;
        CFG_WINDOW_WIDTH: cfg.window_width   <= cfg_data;
        CFG_ACTIVE_LINES: cfg.active_lines   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Room is counted for the item in the read stage as well as the queue.
  assign s_axis_tready = (QLVL_W'(q_level) + QLVL_W'(push)) < QLVL_W'(QDEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  lbc_front #(
    .RAW_PITCH    (RAW_PITCH),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_LINES    (MAX_LINES),
    .ACTIVE_START (ACTIVE_START)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .raw_pixel   (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .cfg         (cfg),
    .push        (push),
    .push_data   (push_data)
  );

  lbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  lbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= QLVL_W'(QDEPTH))
    else $error("result queue overflow");

  a_frame_end_is_line_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without line end");

  a_frame_start_no_emit: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !push)
    else $error("result emitted on frame start transfer");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_level == QLVL_W'(QDEPTH) |-> !s_axis_tready)
    else $error("input ready while queue full");

endmodule

`default_nettype wire

/* verif/line_black_level_clamp_unit_tb.sv */
// Testbench for line_black_level_clamp_unit: streams raw sensor lines through the block,
// predicts every corrected window pixel and checks the output stream against it.
// Depends on lbc_pkg and the RTL of the block.
`default_nettype none

module line_black_level_clamp_unit_tb;
  import lbc_pkg::*;

  localparam int RAW_PITCH      = DEF_RAW_PITCH;
  localparam int MAX_WIDTH      = DEF_MAX_WIDTH;
  localparam int MAX_LINES      = DEF_MAX_LINES;
  localparam int ACTIVE_START   = DEF_ACTIVE_START;
  localparam int DARK_BYTES     = 23;
  localparam int REG_MAX        = 2**CFG_W - 1;
  localparam int PIX_MAX        = 2**PIX_W - 1;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_CYCLES = 5000000;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             line_end;
    logic             frame_end;
  } clamp_pixel_t;

  // How the optical black bytes of a line are filled.
  typedef enum int {
    DARK_MIXED,
    DARK_HIGH,
    DARK_ZERO,
    DARK_NEAR,
    DARK_NOISE
  } dark_fill_t;

  class clamp_scoreboard;
    logic             denoise;
    logic [CFG_W-1:0] win_x;
    logic [CFG_W-1:0] win_width;
    logic [CFG_W-1:0] line_limit;
    int               col;
    int               line_no;
    logic [SUM_W-1:0] dark_acc;
    logic [PIX_W-1:0] black_level;
    logic [PIX_W-1:0] line_store [MAX_WIDTH];
    bit               store_ready;
    clamp_pixel_t     pixels_due[$];
    int               mismatches;

    function new();
      denoise     = 1'b0;
      win_x       = '0;
      win_width   = CFG_W'(MAX_WIDTH);
      line_limit  = CFG_W'(MAX_LINES);
      col         = 0;
      line_no     = 0;
      dark_acc    = '0;
      black_level = '0;
      store_ready = 1'b0;
      mismatches  = 0;
      foreach (line_store[i]) line_store[i] = '0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_DENOISE:      denoise = value[0];
        CFG_WINDOW_X:     win_x = value;
        CFG_WINDOW_WIDTH: win_width = value;
        CFG_ACTIVE_LINES: line_limit = value;
        default: ;
      endcase
    endfunction

    function bit dark_column(int c);
      return (c >= int'(DARK_A_LO) && c < int'(DARK_A_HI)) ||
             (c >= int'(DARK_B_LO) && c < int'(DARK_B_HI));
    endfunction

    // Window width after clipping it to the line store.
    function int window_span();
      if (int'(win_x) >= MAX_WIDTH) return 0;
      if (int'(win_width) > MAX_WIDTH - int'(win_x)) return MAX_WIDTH - int'(win_x);
      return int'(win_width);
    endfunction

    function void take_raw(logic [PIX_W-1:0] raw, logic first);
      int               span;
      int               lines;
      int               base;
      int               c;
      int               level;
      logic [PIX_W-1:0] v;
      clamp_pixel_t     due;
      span  = window_span();
      lines = (int'(line_limit) > MAX_LINES) ? MAX_LINES : int'(line_limit);
      base  = ACTIVE_START + int'(win_x);
      if (first) begin
        col         = 0;
        line_no     = 0;
        dark_acc    = '0;
        store_ready = 1'b0;
      end
      c = col;
      // The held line goes out during the first columns of the following raw line.
      if (store_ready && c < span) begin
        v = line_store[c];
        if (denoise) v = (v >= black_level) ? v - black_level : '0;
        due.pixel     = v;
        due.line_end  = (c + 1 == span);
        due.frame_end = (c + 1 == span) && (line_no == lines);
        pixels_due.push_back(due);
      end
      if (c == 0) dark_acc = '0;
      if (dark_column(c)) dark_acc = dark_acc + raw;
      if (c >= base && c - base < span) line_store[c - base] = raw;
      if (c + 1 >= RAW_PITCH) begin
        level       = int'(dark_acc) / DARK_BYTES;
        black_level = (level > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(level);
        store_ready = line_no < lines;
        if (line_no < int'(LINE_SAT)) line_no++;
        col = 0;
      end else begin
        col = c + 1;
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task match_pixel(logic [PIX_W-1:0] pixel, logic line_end, logic frame_end);
      clamp_pixel_t due;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel %0d arrived with nothing expected", pixel));
      end else begin
        due = pixels_due.pop_front();
        if (pixel !== due.pixel)
          report($sformatf("pixel %0d, expected %0d", pixel, due.pixel));
        if (line_end !== due.line_end)
          report($sformatf("line end %b, expected %b", line_end, due.line_end));
        if (frame_end !== due.frame_end)
          report($sformatf("frame end %b, expected %b", frame_end, due.frame_end));
      end
    endtask

    task flush_leftovers();
      if (pixels_due.size() != 0)
        report($sformatf("%0d expected pixels never arrived", pixels_due.size()));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int send_idle = 32;
  int recv_idle = 87;

  clamp_scoreboard sb;

  line_black_level_clamp_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Output side: check each transfer and pick the next ready value.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.match_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic push_byte(input logic [PIX_W-1:0] raw, input logic first);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.take_raw(raw, first);
  endtask

  function automatic logic [PIX_W-1:0] pixel_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, PIX_MAX));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] dark_byte(dark_fill_t fill, int level);
    int v;
    case (fill)
      DARK_HIGH: return '1;
      DARK_ZERO: return '0;
      DARK_NEAR: begin
        v = level + $urandom_range(0, 8) - 4;
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
        return PIX_W'(v);
      end
      default:   return PIX_W'($urandom_range(0, PIX_MAX));
    endcase
  endfunction

  // Sends whole raw lines, the first byte marked as frame start. A frame start
  // can also land inside a line: at cut_col of the second line, or at random.
  task automatic send_frame(input int n_lines, input int cut_pct, input dark_fill_t fill,
                            input int cut_col);
    int               cut;
    int               level;
    dark_fill_t       kind;
    logic             first;
    logic [PIX_W-1:0] raw;
    for (int ln = 0; ln < n_lines; ln++) begin
      kind  = (fill == DARK_MIXED) ? dark_fill_t'($urandom_range(DARK_HIGH, DARK_NOISE)) : fill;
      level = $urandom_range(0, PIX_MAX);
      cut   = (ln == 1) ? cut_col : -1;
      if ($urandom_range(0, 99) < cut_pct)
        cut = $urandom_range(0, 1) ? $urandom_range(1, 31) : $urandom_range(1, RAW_PITCH - 1);
      for (int c = 0; c < RAW_PITCH; c++) begin
        first = (ln == 0 && c == 0) || c == cut;
        raw   = sb.dark_column(c) ? dark_byte(kind, level) : pixel_byte();
        push_byte(raw, first);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic set_config(input logic den, input logic [CFG_W-1:0] wx,
                            input logic [CFG_W-1:0] ww, input logic [CFG_W-1:0] lines);
    logic [IDX_W-1:0] idx [5];
    logic [CFG_W-1:0] val [5];
    idx[0] = CFG_DENOISE;
    idx[1] = CFG_WINDOW_X;
    idx[2] = CFG_WINDOW_WIDTH;
    idx[3] = CFG_ACTIVE_LINES;
    idx[4] = IDX_W'($urandom_range(int'(CFG_ACTIVE_LINES) + 1, 2**IDX_W - 1));
    val[0] = CFG_W'(den);
    val[1] = wx;
    val[2] = ww;
    val[3] = lines;
    val[4] = CFG_W'($urandom);
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits for the outstanding pixels, then lets the pipeline empty.
  task automatic settle();
    int waited;
    waited = 0;
    while (sb.pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : main_seq
    logic             den;
    logic [CFG_W-1:0] wx;
    logic [CFG_W-1:0] ww;
    logic [CFG_W-1:0] lines;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full window passed through unchanged.
    send_frame(2, 0, DARK_HIGH, -1);
    settle();
    // One pixel wide window at the last column, darkest offset, a single line.
    set_config(1'b1, CFG_W'(MAX_WIDTH - 1), CFG_W'(MAX_WIDTH), CFG_W'(1));
    send_frame(3, 0, DARK_HIGH, -1);
    settle();
    // Zero offset; a frame start drops the held line halfway through its output.
    set_config(1'b1, '0, CFG_W'(5), CFG_W'(2));
    send_frame(3, 0, DARK_ZERO, 2);
    settle();
    // Window beyond the store, zero width and zero lines each emit nothing.
    set_config(1'b0, CFG_W'(REG_MAX), CFG_W'(10), CFG_W'(3));
    send_frame(2, 0, DARK_NOISE, -1);
    settle();
    set_config(1'b1, CFG_W'(100), '0, CFG_W'(MAX_LINES));
    send_frame(2, 0, DARK_NOISE, -1);
    settle();
    set_config(1'b1, CFG_W'(10), CFG_W'(20), '0);
    send_frame(2, 0, DARK_NEAR, -1);
    settle();
    // Oversized width and line count are clipped.
    set_config(1'b1, CFG_W'(40), CFG_W'(REG_MAX), CFG_W'(REG_MAX));
    send_frame(2, 0, DARK_NEAR, -1);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 32 : (mode == 1) ? 87 : 0;
      recv_idle = (mode == 0) ? 87 : (mode == 1) ? 32 : 0;
      repeat (4) begin
        den = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       wx = '0;
          1:       wx = CFG_W'(MAX_WIDTH - 1);
          2:       wx = CFG_W'($urandom_range(MAX_WIDTH, REG_MAX));
          default: wx = CFG_W'($urandom_range(0, MAX_WIDTH - 1));
        endcase
        case ($urandom_range(0, 9))
          0:       ww = CFG_W'($urandom_range(0, REG_MAX));
          1:       ww = CFG_W'(1);
          default: ww = CFG_W'($urandom_range(1, 48));
        endcase
        case ($urandom_range(0, 9))
          0:       lines = '0;
          1:       lines = CFG_W'($urandom_range(MAX_LINES, REG_MAX));
          default: lines = CFG_W'($urandom_range(1, 3));
        endcase
        set_config(den, wx, ww, lines);
        send_frame($urandom_range(2, 4), 15, DARK_MIXED, -1);
        settle();
      end
    end

    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("PASS line_black_level_clamp_unit");
    end else begin
      $display("FAIL line_black_level_clamp_unit");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL line_black_level_clamp_unit");
    $finish;
  end

endmodule

`default_nettype wire
